### src/cylv_pkg.sv
// ----------------------------------------------------------------------------
// cylv_pkg
// Shared types and constants for the cylinder side-wall vertex generator.
// ----------------------------------------------------------------------------
package cylv_pkg;

  // default module parameters
  localparam int DEF_MAX_SEGMENTS       = 1024;
  localparam int DEF_SINE_TABLE_ENTRIES = 1024;
  localparam int DEF_FRAC_BITS          = 16;

  // fixed field widths
  localparam int COORD_W    = 32;
  localparam int LEN_W      = 31;
  localparam int SEG_W      = 11;
  localparam int IDX_W      = 10;
  localparam int COLOR_W    = 32;
  localparam int CORNER_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;

  // register reset values
  localparam logic [LEN_W-1:0]   LEN_RESET   = 31'd65536;
  localparam logic [SEG_W-1:0]   SEG_RESET   = 11'd16;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;

  // pi/2 in Q30, seed of the sine table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X,
    REG_CENTRE_Y,
    REG_CENTRE_Z,
    REG_HEIGHT,
    REG_TOP_DIAM,
    REG_BOT_DIAM,
    REG_SEGMENTS,
    REG_COLOR
  } cfg_reg_e;

  // per-vertex control travelling down the ring pipeline
  typedef struct packed {
    logic                err;
    logic                top;
    logic [CORNER_W-1:0] corner;
    logic                last;
  } vtx_ctl_t;

  // corner order: B(j) T(j) T(j+1) B(j) T(j+1) B(j+1)
  function automatic logic corner_is_top(logic [CORNER_W-1:0] c);
    logic r;
    case (c)
      3'd1, 3'd2, 3'd4: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic corner_uses_next(logic [CORNER_W-1:0] c);
    logic r;
    case (c)
      3'd2, 3'd4, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### src/cylv_recip.sv
// ----------------------------------------------------------------------------
// cylv_recip
// Iterative restoring divider: recip = ceil(2^RECIP_SHIFT / segments),
// one quotient bit per cycle. Runs after reset and after each segment write.
// ----------------------------------------------------------------------------
module cylv_recip #(
  parameter int RECIP_SHIFT = 34
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cylv_pkg::SEG_W-1:0]   divisor_i,
  output logic                         busy_o,
  output logic [RECIP_SHIFT:0]         recip_o
);
  import cylv_pkg::*;

  localparam int QW   = RECIP_SHIFT + 1;
  localparam int CntW = $clog2(QW + 1);

  logic            pend_q, run_q;
  logic [CntW-1:0] cnt_q;
  logic [QW-1:0]   dq_q, dq_d;
  logic [SEG_W-1:0] rem_q, rem_d;
  logic [SEG_W:0]  trial, diff;
  logic            take;

  always_comb begin
    trial = {rem_q, dq_q[QW-1]};
    diff  = trial - {1'b0, divisor_i};
    take  = trial >= {1'b0, divisor_i};
    rem_d = take ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
    dq_d  = {dq_q[QW-2:0], take};
  end

  // pend_q comes up set so the default segment count gets its reciprocal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b1;
      run_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pend_q <= start_i;
      if (pend_q) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(QW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) run_q <= 1'b0;
      end
    end
  end

  // dividend 2^S + s - 1 gives the rounded-up quotient
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      dq_q  <= {1'b1, (QW-1)'(divisor_i - SEG_W'(1))};
      rem_q <= '0;
    end else if (run_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o  = pend_q | run_q;
  assign recip_o = dq_q;

endmodule

### src/cylv_ring_pipe.sv
// ----------------------------------------------------------------------------
// cylv_ring_pipe
// Six-stage vertex pipeline: phase from reciprocal, quadrant fold, sine ROM,
// radius scaling, rounding, centre offset with saturation.
// ----------------------------------------------------------------------------
module cylv_ring_pipe #(
  parameter int SINE_TABLE_ENTRIES = cylv_pkg::DEF_SINE_TABLE_ENTRIES,
  parameter int FRAC_BITS          = cylv_pkg::DEF_FRAC_BITS,
  parameter int RECIP_SHIFT        = 34
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                vld_i,
  input  logic [cylv_pkg::IDX_W-1:0]          k_i,
  input  cylv_pkg::vtx_ctl_t                  ctl_i,
  input  logic [RECIP_SHIFT:0]                recip_i,
  input  logic signed [cylv_pkg::COORD_W-1:0] centre_x_i,
  input  logic signed [cylv_pkg::COORD_W-1:0] centre_y_i,
  input  logic signed [cylv_pkg::COORD_W-1:0] centre_z_i,
  input  logic [cylv_pkg::LEN_W-1:0]          height_i,
  input  logic [cylv_pkg::LEN_W-1:0]          top_diam_i,
  input  logic [cylv_pkg::LEN_W-1:0]          bot_diam_i,
  input  logic [cylv_pkg::COLOR_W-1:0]        color_i,
  output logic                                out_valid_o,
  output logic signed [cylv_pkg::COORD_W-1:0] vert_x_o,
  output logic signed [cylv_pkg::COORD_W-1:0] vert_y_o,
  output logic signed [cylv_pkg::COORD_W-1:0] vert_z_o,
  output logic [cylv_pkg::COLOR_W-1:0]        color_out_o,
  output logic [cylv_pkg::CORNER_W-1:0]       corner_o,
  output logic                                last_vertex_o,
  output logic                                index_error_o
);
  import cylv_pkg::*;

  // table size is a power of two: phase wraps by truncation
  localparam int PhaseW = $clog2(4 * SINE_TABLE_ENTRIES);
  localparam int AddrW  = PhaseW - 1;
  localparam int SinW   = FRAC_BITS + 1;
  localparam int RecipW = RECIP_SHIFT + 1;
  localparam int ProdW  = IDX_W + RecipW;
  localparam int ZLo    = RECIP_SHIFT - PhaseW - 1;
  localparam int ScaleW = LEN_W + SinW;
  localparam int SumW   = COORD_W + 2;
  localparam int TaylorTerms = 7;

  localparam logic [ScaleW-1:0] RoundBit = ScaleW'(1) << FRAC_BITS;
  localparam logic signed [SumW-1:0] CoordMax = SumW'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [SumW-1:0] CoordMin = -CoordMax - SumW'(1);

  typedef logic [SinW-1:0] sine_rom_t [SINE_TABLE_ENTRIES+1];

  // quarter-wave sine, Taylor series to x^15 in Q30, evaluated at elaboration
  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] x, x2, term, sum, s;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x    = HALF_PI_Q30 * 64'(k) / 64'(SINE_TABLE_ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= TaylorTerms; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) sum = sum - term;
        else      sum = sum + term;
      end
      s = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (s > (64'd1 << FRAC_BITS)) s = 64'd1 << FRAC_BITS;
      rom[k] = SinW'(s);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // fold a full-turn phase onto the quarter table: {negate, address}
  function automatic logic [AddrW:0] fold_phase(logic [PhaseW-1:0] ph);
    logic [AddrW-1:0] r, addr;
    r    = AddrW'(ph[PhaseW-3:0]);
    addr = ph[PhaseW-2] ? (AddrW'(SINE_TABLE_ENTRIES) - r) : r;
    return {ph[PhaseW-1], addr};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [SumW-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > CoordMax)      r = CoordMax[COORD_W-1:0];
    else if (v < CoordMin) r = CoordMin[COORD_W-1:0];
    else                   r = v[COORD_W-1:0];
    return r;
  endfunction

  // valid bits
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q;

  // stage payload
  vtx_ctl_t          ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  logic [ProdW-1:0]  prod1_q;
  logic [AddrW-1:0]  s_addr2_q, c_addr2_q;
  logic              s_neg2_q, c_neg2_q, s_neg3_q, c_neg3_q;
  logic              s_neg4_q, c_neg4_q, s_neg5_q, c_neg5_q;
  logic [SinW-1:0]   s_mag3_q, c_mag3_q;
  logic [ScaleW-1:0] s_prod4_q, c_prod4_q;
  logic [LEN_W-1:0]  s_m5_q, c_m5_q;

  // stage 2 phase
  logic [PhaseW:0]   z_lo, z_inc;
  logic [PhaseW-1:0] ph_s, ph_c;
  logic [AddrW:0]    fold_s, fold_c;

  always_comb begin
    z_lo   = prod1_q[ZLo +: PhaseW+1];
    z_inc  = z_lo + (PhaseW+1)'(1);
    ph_s   = z_inc[PhaseW:1];
    ph_c   = ph_s + PhaseW'(SINE_TABLE_ENTRIES);
    fold_s = fold_phase(ph_s);
    fold_c = fold_phase(ph_c);
  end

  // stage 4 radius
  logic [LEN_W-1:0] diam;
  assign diam = ctl3_q.top ? top_diam_i : bot_diam_i;

  // stage 5 rounding
  logic [ScaleW-1:0] s_rnd, c_rnd;
  assign s_rnd = s_prod4_q + RoundBit;
  assign c_rnd = c_prod4_q + RoundBit;

  // stage 6 final sums
  logic signed [SumW-1:0] s_mx, c_mx, x_sum, y_sum, z_sum, hh_x;
  logic [LEN_W:0]         h_inc;

  always_comb begin
    s_mx  = $signed(SumW'(s_m5_q));
    c_mx  = $signed(SumW'(c_m5_q));
    h_inc = {1'b0, height_i} + (LEN_W+1)'(1);
    hh_x  = $signed(SumW'(h_inc[LEN_W:1]));
    x_sum = SumW'(centre_x_i) + (c_neg5_q ? -c_mx : c_mx);
    z_sum = SumW'(centre_z_i) + (s_neg5_q ? s_mx : -s_mx);
    y_sum = ctl5_q.top ? SumW'(centre_y_i) + hh_x : SumW'(centre_y_i) - hh_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // 1: phase numerator times reciprocal
      ctl1_q  <= ctl_i;
      prod1_q <= ProdW'(k_i) * ProdW'(recip_i);
      // 2: quadrant fold for sine and cosine
      ctl2_q    <= ctl1_q;
      s_addr2_q <= fold_s[AddrW-1:0];
      s_neg2_q  <= fold_s[AddrW];
      c_addr2_q <= fold_c[AddrW-1:0];
      c_neg2_q  <= fold_c[AddrW];
      // 3: table read
      ctl3_q   <= ctl2_q;
      s_mag3_q <= SINE_ROM[s_addr2_q];
      c_mag3_q <= SINE_ROM[c_addr2_q];
      s_neg3_q <= s_neg2_q;
      c_neg3_q <= c_neg2_q;
      // 4: diameter times table value
      ctl4_q    <= ctl3_q;
      s_prod4_q <= ScaleW'(diam) * ScaleW'(s_mag3_q);
      c_prod4_q <= ScaleW'(diam) * ScaleW'(c_mag3_q);
      s_neg4_q  <= s_neg3_q;
      c_neg4_q  <= c_neg3_q;
      // 5: half and round, ties away from zero on the magnitude
      ctl5_q   <= ctl4_q;
      s_m5_q   <= s_rnd[FRAC_BITS+1 +: LEN_W];
      c_m5_q   <= c_rnd[FRAC_BITS+1 +: LEN_W];
      s_neg5_q <= s_neg4_q;
      c_neg5_q <= c_neg4_q;
      // 6: output register
      corner_o      <= ctl5_q.err ? '0 : ctl5_q.corner;
      last_vertex_o <= ctl5_q.last;
      index_error_o <= ctl5_q.err;
      if (ctl5_q.err) begin
        vert_x_o    <= '0;
        vert_y_o    <= '0;
        vert_z_o    <= '0;
        color_out_o <= '0;
      end else begin
        vert_x_o    <= sat_coord(x_sum);
        vert_y_o    <= sat_coord(y_sum);
        vert_z_o    <= sat_coord(z_sum);
        color_out_o <= color_i;
      end
    end
  end

  assign out_valid_o = vld6_q;

endmodule

### src/cylinder_side_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// cylinder_side_vertex_generator_top
// Emits the six side-wall vertices of one segment of a truncated cylinder.
//
//   channel | signals                               | transfer when
//   --------+---------------------------------------+-------------------------
//   in      | in_valid_i in_ready_o segment_index_i | in_valid_i & in_ready_o
//   out     | out_valid_o out_ready_i vert_*, ...   | out_valid_o & out_ready_i
//   cfg     | cfg_we_i cfg_idx_i cfg_data_i         | cfg_we_i
//
// One vertex leaves per cycle while the output is not stalled: a segment gives
// six vertices, a bad index one. The first vertex passes through the sequencer
// register and the six-stage ring pipeline after the input transfer.
// After reset and after each write of the segment count, in_ready_o stays low
// while the reciprocal is rebuilt. An output stall freezes the whole pipeline;
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module cylinder_side_vertex_generator_top #(
  parameter int MAX_SEGMENTS       = cylv_pkg::DEF_MAX_SEGMENTS,
  parameter int SINE_TABLE_ENTRIES = cylv_pkg::DEF_SINE_TABLE_ENTRIES,
  parameter int FRAC_BITS          = cylv_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cylv_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cylv_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cylv_pkg::IDX_W-1:0]          segment_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cylv_pkg::COORD_W-1:0] vert_x_o,
  output logic signed [cylv_pkg::COORD_W-1:0] vert_y_o,
  output logic signed [cylv_pkg::COORD_W-1:0] vert_z_o,
  output logic [cylv_pkg::COLOR_W-1:0]        color_out_o,
  output logic [cylv_pkg::CORNER_W-1:0]       corner_o,
  output logic                                last_vertex_o,
  output logic                                index_error_o
);
  import cylv_pkg::*;

  // quotient precision exact for index * 8N / segments
  localparam int PhaseW      = $clog2(4 * SINE_TABLE_ENTRIES);
  localparam int RecipShift  = PhaseW + 1 + IDX_W + SEG_W;
  localparam int SegCap      = (MAX_SEGMENTS < 2047) ? MAX_SEGMENTS : 2047;

  // configuration registers
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [LEN_W-1:0]          height_q, top_d_q, bot_d_q;
  logic [SEG_W-1:0]          seg_q;
  logic [COLOR_W-1:0]        color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      height_q <= LEN_RESET;
      top_d_q  <= LEN_RESET;
      bot_d_q  <= LEN_RESET;
      seg_q    <= SEG_RESET;
      color_q  <= COLOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTRE_X: cx_q     <= cfg_data_i;
        REG_CENTRE_Y: cy_q     <= cfg_data_i;
        REG_CENTRE_Z: cz_q     <= cfg_data_i;
        REG_HEIGHT:   height_q <= cfg_data_i[LEN_W-1:0];
        REG_TOP_DIAM: top_d_q  <= cfg_data_i[LEN_W-1:0];
        REG_BOT_DIAM: bot_d_q  <= cfg_data_i[LEN_W-1:0];
        REG_SEGMENTS: seg_q    <= cfg_data_i[SEG_W-1:0];
        REG_COLOR:    color_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             seg_wr;
  logic [SEG_W-1:0] seg_eff;

  assign seg_wr  = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_SEGMENTS);
  assign seg_eff = (seg_q > SEG_W'(SegCap)) ? SEG_W'(SegCap) : seg_q;

  logic                recip_busy;
  logic [RecipShift:0] recip;

  cylv_recip #(
    .RECIP_SHIFT(RecipShift)
  ) u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (seg_wr),
    .divisor_i(seg_eff),
    .busy_o   (recip_busy),
    .recip_o  (recip)
  );

  // segment sequencer: walks the six corners of the held segment
  logic                busy_q;
  logic [CORNER_W-1:0] corner_q;
  logic [IDX_W-1:0]    idx_q, nxt_q;
  logic                err_q;

  logic                adv, issue, seq_last, accept;
  logic [SEG_W-1:0]    idx_inc;
  logic                in_err;
  logic [IDX_W-1:0]    in_next, k_sel;
  vtx_ctl_t            ctl;

  always_comb begin
    adv        = !out_valid_o || out_ready_i;
    issue      = busy_q && adv;
    seq_last   = err_q || (corner_q == LAST_CORNER);
    in_ready_o = !recip_busy && (!busy_q || (issue && seq_last));
    accept     = in_valid_i && in_ready_o;
    idx_inc    = {1'b0, segment_index_i} + SEG_W'(1);
    in_err     = {1'b0, segment_index_i} >= seg_eff;
    in_next    = (idx_inc >= seg_eff) ? '0 : idx_inc[IDX_W-1:0];
    k_sel      = corner_uses_next(corner_q) ? nxt_q : idx_q;
    ctl.err    = err_q;
    ctl.top    = corner_is_top(corner_q);
    ctl.corner = corner_q;
    ctl.last   = seq_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      corner_q <= '0;
    end else if (accept) begin
      busy_q   <= 1'b1;
      corner_q <= '0;
    end else if (issue) begin
      if (seq_last) busy_q <= 1'b0;
      else          corner_q <= corner_q + CORNER_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= segment_index_i;
      nxt_q <= in_next;
      err_q <= in_err;
    end
  end

  cylv_ring_pipe #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
    .FRAC_BITS         (FRAC_BITS),
    .RECIP_SHIFT       (RecipShift)
  ) u_ring_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .vld_i        (busy_q),
    .k_i          (k_sel),
    .ctl_i        (ctl),
    .recip_i      (recip),
    .centre_x_i   (cx_q),
    .centre_y_i   (cy_q),
    .centre_z_i   (cz_q),
    .height_i     (height_q),
    .top_diam_i   (top_d_q),
    .bot_diam_i   (bot_d_q),
    .color_i      (color_q),
    .out_valid_o  (out_valid_o),
    .vert_x_o     (vert_x_o),
    .vert_y_o     (vert_y_o),
    .vert_z_o     (vert_z_o),
    .color_out_o  (color_out_o),
    .corner_o     (corner_o),
    .last_vertex_o(last_vertex_o),
    .index_error_o(index_error_o)
  );

endmodule

### sim/cylinder_side_vertex_generator_top_test.sv
// ----------------------------------------------------------------------------
// cylinder_side_vertex_generator_top_test
// Drives segment indices into the side-wall vertex generator and predicts the
// six vertices of each segment, or the single error vertex for an index past
// the segment count. Runs a directed set over register extremes and odd
// segment counts, then random phases with random register settings, random
// gaps on both channels, a long output stall and a full drain mid-phase.
// ----------------------------------------------------------------------------
module cylinder_side_vertex_generator_top_test;
  import cylv_pkg::*;

  localparam int N_SINE      = DEF_SINE_TABLE_ENTRIES;
  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int SEG_MAX     = DEF_MAX_SEGMENTS;
  localparam int QUIET_LIMIT = 3000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [COLOR_W-1:0]  color;
    logic [CORNER_W-1:0] corner;
    logic                last;
    logic                err;
  } vertex_t;

  class vertex_scoreboard;
    longint unsigned  sine_q [0:N_SINE];
    logic [31:0]      cx, cy, cz, color;
    logic [LEN_W-1:0] height, top_d, bot_d;
    logic [SEG_W-1:0] seg_reg;
    vertex_t          due_vertices [$];
    int               errors;
    int               printed;

    function new();
      longint unsigned x, x2, term, acc, s;
      // quarter-wave table, Taylor series to x^15 in Q30
      for (int k = 0; k <= N_SINE; k++) begin
        x = HALF_PI_Q30 * k / N_SINE;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (int n = 1; n <= 7; n++) begin
          term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
          if (n % 2 == 1) acc -= term;
          else acc += term;
        end
        s = (acc + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        if (s > (64'd1 << FRAC)) s = 64'd1 << FRAC;
        sine_q[k] = s;
      end
      cx = '0;
      cy = '0;
      cz = '0;
      height = LEN_RESET;
      top_d = LEN_RESET;
      bot_d = LEN_RESET;
      seg_reg = SEG_RESET;
      color = COLOR_RESET;
      errors = 0;
      printed = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (cfg_reg_e'(idx))
        REG_CENTRE_X: cx = d;
        REG_CENTRE_Y: cy = d;
        REG_CENTRE_Z: cz = d;
        REG_HEIGHT:   height = d[LEN_W-1:0];
        REG_TOP_DIAM: top_d = d[LEN_W-1:0];
        REG_BOT_DIAM: bot_d = d[LEN_W-1:0];
        REG_SEGMENTS: seg_reg = d[SEG_W-1:0];
        REG_COLOR:    color = d;
        default: ;
      endcase
    endfunction

    function int effective_segments();
      return (seg_reg > SEG_MAX) ? SEG_MAX : int'(seg_reg);
    endfunction

    // p counts 4*N_SINE steps per turn
    function longint sine_at(int p);
      int     q, r;
      longint v;
      q = p / N_SINE;
      r = p % N_SINE;
      v = (q % 2 == 1) ? longint'(sine_q[N_SINE - r]) : longint'(sine_q[r]);
      return (q >= 2) ? -v : v;
    endfunction

    // d*t/2, magnitude rounded half away from zero
    function longint scaled_radius(longint unsigned diam, longint t);
      longint unsigned mag, m;
      mag = (t < 0) ? -t : t;
      m = (diam * mag + (64'd1 << FRAC)) >> (FRAC + 1);
      return (t < 0) ? -longint'(m) : longint'(m);
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void ring_point(int k, int seg, bit top,
                             output logic [31:0] px, py, pz);
      int              p, pc;
      longint unsigned diam;
      longint          hh, cx_s, cy_s, cz_s;
      p = (8 * N_SINE * k + seg) / (2 * seg);
      if (p >= 4 * N_SINE) p -= 4 * N_SINE;
      pc = p + N_SINE;
      if (pc >= 4 * N_SINE) pc -= 4 * N_SINE;
      diam = top ? top_d : bot_d;
      hh = (longint'(height) + 1) >> 1;
      cx_s = $signed(cx);
      cy_s = $signed(cy);
      cz_s = $signed(cz);
      px = clamp32(cx_s + scaled_radius(diam, sine_at(pc)));
      py = clamp32(top ? cy_s + hh : cy_s - hh);
      pz = clamp32(cz_s - scaled_radius(diam, sine_at(p)));
    endfunction

    function void predict_segment(logic [IDX_W-1:0] idx);
      bit      ring_top [6];
      bit      use_next [6];
      int      seg, j, jn;
      vertex_t v;
      ring_top = '{0, 1, 1, 0, 1, 0};
      use_next = '{0, 0, 1, 0, 1, 1};
      seg = effective_segments();
      j = int'(idx);
      if (j >= seg) begin
        v = '0;
        v.last = 1'b1;
        v.err = 1'b1;
        due_vertices.push_back(v);
        return;
      end
      jn = (j + 1 >= seg) ? 0 : j + 1;
      for (int c = 0; c < 6; c++) begin
        ring_point(use_next[c] ? jn : j, seg, ring_top[c], v.x, v.y, v.z);
        v.color = color;
        v.corner = CORNER_W'(c);
        v.last = (v.corner == LAST_CORNER);
        v.err = 1'b0;
        due_vertices.push_back(v);
      end
    endfunction

    task report(string what);
      errors++;
      if (printed < PRINT_LIMIT) begin
        printed++;
        $display("mismatch: %s", what);
      end
    endtask

    task check_vertex(vertex_t got);
      vertex_t e;
      if (due_vertices.size() == 0) begin
        report($sformatf("vertex with nothing due, corner %0d err %0b",
                         got.corner, got.err));
        return;
      end
      e = due_vertices.pop_front();
      if (got.x !== e.x)
        report($sformatf("x %0d, want %0d (corner %0d)", $signed(got.x),
                         $signed(e.x), e.corner));
      if (got.y !== e.y)
        report($sformatf("y %0d, want %0d (corner %0d)", $signed(got.y),
                         $signed(e.y), e.corner));
      if (got.z !== e.z)
        report($sformatf("z %0d, want %0d (corner %0d)", $signed(got.z),
                         $signed(e.z), e.corner));
      if (got.color !== e.color)
        report($sformatf("color %h, want %h", got.color, e.color));
      if (got.corner !== e.corner)
        report($sformatf("corner %0d, want %0d", got.corner, e.corner));
      if (got.last !== e.last)
        report($sformatf("last %b, want %b (corner %0d)", got.last, e.last, e.corner));
      if (got.err !== e.err)
        report($sformatf("index error %b, want %b", got.err, e.err));
    endtask

    function int pending();
      return due_vertices.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [IDX_W-1:0]      segment_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] vert_x_o, vert_y_o, vert_z_o;
  logic [COLOR_W-1:0]    color_out_o;
  logic [CORNER_W-1:0]   corner_o;
  logic                  last_vertex_o;
  logic                  index_error_o;

  vertex_scoreboard sb;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit moved;

  cylinder_side_vertex_generator_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .segment_index_i (segment_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .vert_x_o        (vert_x_o),
    .vert_y_o        (vert_y_o),
    .vert_z_o        (vert_z_o),
    .color_out_o     (color_out_o),
    .corner_o        (corner_o),
    .last_vertex_o   (last_vertex_o),
    .index_error_o   (index_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int eff, roll;
    eff = sb.effective_segments();
    roll = $urandom_range(0, 99);
    if (eff > 0 && roll < 10) return IDX_W'(eff - 1);
    if (eff > 0 && roll < 80) return IDX_W'($urandom_range(0, eff - 1));
    if (eff < (1 << IDX_W) && roll < 90) return IDX_W'(eff);
    return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
  endfunction

  function automatic logic [31:0] pick_coord();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'h7FFF_FFFF;
    if (roll == 1) return 32'h8000_0000;
    if (roll == 2) return 32'h0;
    if (roll < 6) return $urandom();
    return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
  endfunction

  // top bit is random junk, the register drops it
  function automatic logic [31:0] pick_length();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'h0;
    if (roll == 1) return 32'hFFFF_FFFF;
    if (roll < 4) return $urandom();
    return $urandom_range(0, 32'h0040_0000) | ($urandom() & 32'h8000_0000);
  endfunction

  task automatic set_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= d;
    @(posedge clk_i);
  endtask

  task automatic random_config();
    int          roll;
    logic [31:0] count;
    roll = $urandom_range(0, 9);
    if (roll == 0) count = 3;
    else if (roll == 1) count = SEG_MAX;
    else if (roll < 5) count = $urandom_range(3, SEG_MAX);
    else count = $urandom_range(3, 40);
    set_reg(REG_CENTRE_X, pick_coord());
    set_reg(REG_CENTRE_Y, pick_coord());
    set_reg(REG_CENTRE_Z, pick_coord());
    set_reg(REG_HEIGHT, pick_length());
    set_reg(REG_TOP_DIAM, pick_length());
    set_reg(REG_BOT_DIAM, pick_length());
    set_reg(REG_SEGMENTS, count | ($urandom() & 32'hFFFF_F800));
    set_reg(REG_COLOR, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  // valid is only lowered when a gap follows, never in the step it rises
  task automatic send_index(logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    segment_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic run_items(int count);
    for (int i = 0; i < count; i++) send_index(pick_index());
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int roll;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 399;
        out_ready_i <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 70) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
        end
      end
    end
  end

  // transfer monitor and watchdog; values seen here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) begin
        sb.write_reg(cfg_idx_i, cfg_data_i);
        moved = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        sb.predict_segment(segment_index_i);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_vertex({vert_x_o, vert_y_o, vert_z_o, color_out_o, corner_o,
                         last_vertex_o, index_error_o});
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, 16 segments
    send_index(0);
    send_index(15);
    send_index(16);
    send_index(1023);
    send_index(8);
    send_index(4);
    send_index(12);
    drain_results();

    // saturation on every coordinate, zero bottom ring
    set_reg(REG_CENTRE_X, 32'h7FFF_FFFF);
    set_reg(REG_CENTRE_Y, 32'h8000_0000);
    set_reg(REG_CENTRE_Z, 32'h8000_0000);
    set_reg(REG_HEIGHT, 32'h7FFF_FFFF);
    set_reg(REG_TOP_DIAM, 32'h7FFF_FFFF);
    set_reg(REG_BOT_DIAM, 32'h0);
    set_reg(REG_SEGMENTS, SEG_MAX);
    set_reg(REG_COLOR, 32'h0);
    cfg_we_i <= 1'b0;
    send_index(0);
    send_index(1023);
    send_index(256);
    send_index(512);
    send_index(768);
    drain_results();

    // opposite extremes, fewest regular segments, junk in the upper bits
    set_reg(REG_CENTRE_X, 32'h8000_0000);
    set_reg(REG_CENTRE_Y, 32'h7FFF_FFFF);
    set_reg(REG_CENTRE_Z, 32'h7FFF_FFFF);
    set_reg(REG_HEIGHT, 32'h8000_0000);
    set_reg(REG_TOP_DIAM, 32'h0);
    set_reg(REG_BOT_DIAM, 32'hFFFF_FFFF);
    set_reg(REG_SEGMENTS, 32'hFFFF_F803);
    set_reg(REG_COLOR, 32'hA5A5_5A5A);
    cfg_we_i <= 1'b0;
    send_index(0);
    send_index(1);
    send_index(2);
    send_index(3);
    send_index(1023);
    drain_results();

    // no segments: every index is out of range
    set_reg(REG_SEGMENTS, 32'h0);
    cfg_we_i <= 1'b0;
    send_index(0);
    send_index(1023);
    drain_results();

    // single segment wraps onto itself
    set_reg(REG_SEGMENTS, 32'h1);
    cfg_we_i <= 1'b0;
    send_index(0);
    send_index(1);
    drain_results();

    set_reg(REG_SEGMENTS, 32'h2);
    cfg_we_i <= 1'b0;
    send_index(0);
    send_index(1);
    drain_results();

    // count above the maximum is clipped
    set_reg(REG_SEGMENTS, 32'h7FF);
    cfg_we_i <= 1'b0;
    send_index(1023);
    send_index(0);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      random_config();
      idle_on = (ph != 0);
      if (ph == 2) hold_req = 1'b1;
      if (ph == 3) begin
        run_items(24);
        drain_results();
        run_items(24);
      end else begin
        run_items(48);
      end
    end

    drain_results();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
